// ===== rtl/vfrs_pkg.sv =====
// Video frame ring selector: shared types and constants.
// Used by every module under rtl; depends on nothing.
package vfrs_pkg;

  localparam int SLOT_W    = 4;
  localparam int FID_W     = 16;
  localparam int MAGIC_W   = 32;
  localparam int STATUS_W  = 8;
  localparam int LAG_W     = 4;
  localparam int COUNT_W   = 5;
  localparam int STEP_W    = 4;
  localparam int PROBE_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0]   COUNT_MAX  = 5'd31;
  localparam logic [PROBE_W-1:0]   PROBE_LAST = 3'd4;
  localparam logic [MAGIC_W-1:0]   HEADER_MAGIC_RST = 32'hAAABACAD;
  localparam logic [MAGIC_W-1:0]   TAIL_MAGIC_RST   = 32'hFAFBFCFD;
  localparam logic [STATUS_W-1:0]  GOOD_STATUS_RST  = 8'h01;
  localparam logic [LAG_W-1:0]     DISPLAY_LAG_RST  = 4'd3;

  // Operation codes carried in the input beat
  localparam logic OP_FRAME_DONE = 1'b0;
  localparam logic OP_DISPLAY    = 1'b1;

  // Move from probe k to probe k+1: offsets 0, +1, -1, +2, -2 around the aim
  localparam logic signed [STEP_W-1:0] PROBE_STEP [4] = '{4'sd1, -4'sd2, 4'sd3, -4'sd4};
  localparam logic signed [STEP_W-1:0] STEP_BACK = -4'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_MAGIC = 2'd0,
    CFG_TAIL_MAGIC   = 2'd1,
    CFG_GOOD_STATUS  = 2'd2,
    CFG_DISPLAY_LAG  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BASE,
    ST_PROBE,
    ST_DONE
  } vfrs_state_t;

  typedef struct packed {
    logic                operation;
    logic [FID_W-1:0]    source_frame_id;
    logic [MAGIC_W-1:0]  header_magic_seen;
    logic [MAGIC_W-1:0]  tail_magic_seen;
    logic [STATUS_W-1:0] tail_status_seen;
  } vfrs_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] armed_slot;
    logic              found;
    logic [SLOT_W-1:0] display_slot;
    logic [FID_W-1:0]  display_frame_id;
  } vfrs_out_t;

  // Frame-done write into the ring
  typedef struct packed {
    logic             commit;
    logic             good;
    logic [FID_W-1:0] fid;
  } ring_wr_t;

  // Slot entry seen at the probe address
  typedef struct packed {
    logic             ready;
    logic             good;
    logic [FID_W-1:0] fid;
  } ring_rd_t;

endpackage

// ===== rtl/vfrs_wrap_add.sv =====
// Shared ring-index adder: slot index plus a small signed step, wrapped into the ring.
// Depends on vfrs_pkg.
module vfrs_wrap_add #(
  parameter int SLOTS = 5
) (
  input  logic [vfrs_pkg::SLOT_W-1:0]        slot_in,
  input  logic signed [vfrs_pkg::STEP_W-1:0] step,
  output logic [vfrs_pkg::SLOT_W-1:0]        slot_out
);
  import vfrs_pkg::*;

  localparam int SUM_W = SLOT_W + 2;
  localparam logic signed [SUM_W-1:0] SLOTS_S = SUM_W'(SLOTS);

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] wrapped;

  // One correction suffices: step magnitude stays below the ring size
  always_comb begin
    sum = $signed({2'b00, slot_in}) + SUM_W'(step);
    if (sum < 0) begin
      wrapped = sum + SLOTS_S;
    end else if (sum >= SLOTS_S) begin
      wrapped = sum - SLOTS_S;
    end else begin
      wrapped = sum;
    end
  end

  assign slot_out = wrapped[SLOT_W-1:0];

endmodule

// ===== rtl/vfrs_ring.sv =====
// Slot ring state: ready marks, good flags, frame ids, armed slot, completion count.
// Depends on vfrs_pkg.
module vfrs_ring #(
  parameter int SLOTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vfrs_pkg::ring_wr_t            wr,
  input  logic [vfrs_pkg::SLOT_W-1:0]   rd_addr,
  output vfrs_pkg::ring_rd_t            rd,
  output logic [vfrs_pkg::SLOT_W-1:0]   active_slot,
  output logic [vfrs_pkg::COUNT_W-1:0]  completed_count
);
  import vfrs_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic             ready_r [SLOTS];
  logic             good_r  [SLOTS];
  logic [FID_W-1:0] fid_r   [SLOTS];
  logic [SLOT_W-1:0]  active_r;
  logic [COUNT_W-1:0] count_r;

  logic [SLOT_W-1:0] arm_slot;
  logic [IDX_W-1:0]  cur_i;
  logic [IDX_W-1:0]  nxt_i;
  logic [IDX_W-1:0]  rd_i;

  assign arm_slot = (active_r == LAST_SLOT) ? '0 : active_r + 1'b1;
  assign cur_i    = active_r[IDX_W-1:0];
  assign nxt_i    = arm_slot[IDX_W-1:0];
  assign rd_i     = rd_addr[IDX_W-1:0];

  // Frame done: mark current ready, arm the next slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        ready_r[i] <= 1'b0;
        fid_r[i]   <= '0;
      end
      active_r <= '0;
      count_r  <= '0;
    end else if (wr.commit) begin
      ready_r[cur_i] <= 1'b1;
      ready_r[nxt_i] <= 1'b0;
      fid_r[nxt_i]   <= wr.fid;
      active_r       <= arm_slot;
      if (count_r != COUNT_MAX) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  // Good flag only matters once the slot is ready, so no reset
  always_ff @(posedge clk) begin
    if (wr.commit) begin
      good_r[cur_i] <= wr.good;
    end
  end

  assign rd.ready        = ready_r[rd_i];
  assign rd.good         = good_r[rd_i];
  assign rd.fid          = fid_r[rd_i];
  assign active_slot     = active_r;
  assign completed_count = count_r;

  // Armed slot always lies inside the ring
  a_active_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    active_r <= LAST_SLOT)
    else $error("armed slot outside ring");

  // Counter holds once full
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.commit && count_r == COUNT_MAX) |=> count_r == COUNT_MAX)
    else $error("completion counter wrapped");

  // Slot just completed reads ready on the next cycle
  a_done_marks_ready: assert property (@(posedge clk) disable iff (!rst_n)
    wr.commit |=> ready_r[$past(cur_i)])
    else $error("completed slot not marked ready");

endmodule

// ===== rtl/vfrs_seq.sv =====
// Item sequencer: frame-done commit, aim stepping and candidate probing over the
// shared wrap adder. Depends on vfrs_pkg and vfrs_wrap_add.
module vfrs_seq #(
  parameter int SLOTS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          operation,
  input  logic [vfrs_pkg::FID_W-1:0]    source_frame_id,
  input  logic                          frame_good,
  input  logic [vfrs_pkg::LAG_W-1:0]    display_lag,
  input  logic [vfrs_pkg::COUNT_W-1:0]  completed_count,
  input  logic [vfrs_pkg::SLOT_W-1:0]   active_slot,
  input  vfrs_pkg::ring_rd_t            rd,
  output logic [vfrs_pkg::SLOT_W-1:0]   rd_addr,
  output vfrs_pkg::ring_wr_t            wr,
  input  logic                          out_free,
  output logic                          res_load,
  output logic                          res_found,
  output logic [vfrs_pkg::SLOT_W-1:0]   res_slot,
  output logic [vfrs_pkg::FID_W-1:0]    res_fid
);
  import vfrs_pkg::*;

  vfrs_state_t        state_r, state_nxt;
  logic [SLOT_W-1:0]  acc_r, acc_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PROBE_W-1:0] k_r, k_nxt;
  logic               found_r, found_nxt;
  logic [FID_W-1:0]   fid_r, fid_nxt;

  logic               accept;
  logic               enough;
  logic               hit;
  logic signed [STEP_W-1:0] unit_step;
  logic [SLOT_W-1:0]  unit_out;

  assign accept = in_valid && in_ready;
  assign enough = completed_count >= ({1'b0, display_lag} + 5'd1);
  assign hit    = rd.ready && rd.good;

  // Shared adder: one step back while aiming, probe moves afterwards
  assign unit_step = (state_r == ST_BASE) ? STEP_BACK : PROBE_STEP[k_r[1:0]];

  vfrs_wrap_add #(.SLOTS(SLOTS)) u_add (
    .slot_in  (acc_r),
    .step     (unit_step),
    .slot_out (unit_out)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (operation == OP_FRAME_DONE || !enough) ? ST_DONE : ST_BASE;
        end
      end
      ST_BASE: begin
        if (step_r == '0) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit || k_r == PROBE_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    res_load  = (state_r == ST_DONE) && out_free;
    wr.commit = accept && (operation == OP_FRAME_DONE);
    wr.good   = frame_good;
    wr.fid    = source_frame_id;
  end

  // Datapath next values
  always_comb begin
    acc_nxt   = acc_r;
    step_nxt  = step_r;
    k_nxt     = k_r;
    found_nxt = found_r;
    fid_nxt   = fid_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          acc_nxt   = active_slot;
          step_nxt  = display_lag;
          k_nxt     = '0;
          found_nxt = 1'b0;
        end
      end
      ST_BASE: begin
        acc_nxt  = unit_out;
        step_nxt = step_r - 1'b1;
      end
      ST_PROBE: begin
        if (hit) begin
          found_nxt = 1'b1;
          fid_nxt   = rd.fid;
        end else if (k_r != PROBE_LAST) begin
          acc_nxt = unit_out;
          k_nxt   = k_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    k_r    <= k_nxt;
    fid_r  <= fid_nxt;
  end

  assign rd_addr   = acc_r;
  assign res_found = found_r;
  assign res_slot  = found_r ? acc_r : '0;
  assign res_fid   = found_r ? fid_r : '0;

  // Probe count never passes the last candidate
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (k_r <= PROBE_LAST))
    else $error("probe index past last candidate");

  // Probe address stays inside the ring
  a_probe_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (acc_r < SLOT_W'(SLOTS)))
    else $error("probe address outside ring");

  // A hit ends the search with a found result
  a_hit_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && hit) |=> (state_r == ST_DONE && found_r))
    else $error("hit not reported");

  // A frame-done beat never reports a found slot
  a_commit_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    wr.commit |=> (state_r == ST_DONE && !found_r))
    else $error("frame-done result marked found");

endmodule

// ===== rtl/video_frame_ring_selector.sv =====
// Video frame ring selector top level: config registers, frame check, result register.
// Depends on vfrs_pkg, vfrs_ring, vfrs_seq (and vfrs_wrap_add through it).
//
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid  in_ready  in_data    | frame-done event or display request
//  out     | out_valid out_ready out_data   | armed slot and display choice
//  cfg     | cfg_valid cfg_ready cfg_index  | register write, always taken
//          | cfg_data                       |
//
// A frame-done beat goes straight to the final state, as does a display request when
// too few frames have completed; else the shared wrap adder steps back from the armed
// slot one slot at a time to the aim, then makes up to 5 probes, one probe a cycle.
// Input is refused while an item is in progress; a stalled result holds the block
// in its final state. Synchronous active-low reset clears the ring but its good flags.
module video_frame_ring_selector #(
  parameter int SLOTS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  vfrs_pkg::vfrs_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output vfrs_pkg::vfrs_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vfrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vfrs_pkg::MAGIC_W-1:0]      cfg_data
);
  import vfrs_pkg::*;

  logic [MAGIC_W-1:0]  header_magic_r;
  logic [MAGIC_W-1:0]  tail_magic_r;
  logic [STATUS_W-1:0] good_status_r;
  logic [LAG_W-1:0]    display_lag_r;

  logic               frame_good;
  ring_wr_t           wr;
  ring_rd_t           rd;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  active_slot;
  logic [COUNT_W-1:0] completed_count;
  logic               out_free;
  logic               res_load;
  logic               res_found;
  logic [SLOT_W-1:0]  res_slot;
  logic [FID_W-1:0]   res_fid;

  logic      out_valid_r;
  vfrs_out_t out_data_r;

  // Config writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_magic_r <= HEADER_MAGIC_RST;
      tail_magic_r   <= TAIL_MAGIC_RST;
      good_status_r  <= GOOD_STATUS_RST;
      display_lag_r  <= DISPLAY_LAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEADER_MAGIC: header_magic_r <= cfg_data;
        CFG_TAIL_MAGIC:   tail_magic_r   <= cfg_data;
        CFG_GOOD_STATUS:  good_status_r  <= cfg_data[STATUS_W-1:0];
        CFG_DISPLAY_LAG:  display_lag_r  <= cfg_data[LAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame check: header magic, tail magic and tail status
  assign frame_good = (in_data.header_magic_seen == header_magic_r) &&
                      (in_data.tail_magic_seen   == tail_magic_r) &&
                      (in_data.tail_status_seen  == good_status_r);

  vfrs_ring #(.SLOTS(SLOTS)) u_ring (
    .clk             (clk),
    .rst_n           (rst_n),
    .wr              (wr),
    .rd_addr         (rd_addr),
    .rd              (rd),
    .active_slot     (active_slot),
    .completed_count (completed_count)
  );

  vfrs_seq #(.SLOTS(SLOTS)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (in_data.operation),
    .source_frame_id (in_data.source_frame_id),
    .frame_good      (frame_good),
    .display_lag     (display_lag_r),
    .completed_count (completed_count),
    .active_slot     (active_slot),
    .rd              (rd),
    .rd_addr         (rd_addr),
    .wr              (wr),
    .out_free        (out_free),
    .res_load        (res_load),
    .res_found       (res_found),
    .res_slot        (res_slot),
    .res_fid         (res_fid)
  );

  // Result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r.armed_slot       <= active_slot;
      out_data_r.found            <= res_found;
      out_data_r.display_slot     <= res_slot;
      out_data_r.display_frame_id <= res_fid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A not-found result carries zero slot and id
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.found) |->
      (out_data_r.display_slot == '0 && out_data_r.display_frame_id == '0))
    else $error("not-found result with nonzero slot or id");

  // Input is never taken while a result is being loaded
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !in_ready)
    else $error("input taken during result load");

  // Armed slot reported lies inside the ring
  a_armed_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.armed_slot < SLOT_W'(SLOTS)))
    else $error("armed slot outside ring");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for video_frame_ring_selector: directed and random beats
// checked against an in-bench model of the slot ring. Depends on rtl/vfrs_pkg.sv and
// the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vfrs_pkg::*;

  localparam int RING = 5;
  localparam int RANDOM_BEATS = 170;

  logic clk;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  vfrs_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  vfrs_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index = CFG_HEADER_MAGIC;
  logic [MAGIC_W-1:0] cfg_data = '0;

  // Idle rates in percent, changed per phase
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  vfrs_in_t  pending_beats[$];
  vfrs_out_t expected_results[$];
  logic      in_fire_q = 1'b0;
  int unsigned mismatches = 0;

  // Register copies
  logic [MAGIC_W-1:0]  reg_header_magic = HEADER_MAGIC_RST;
  logic [MAGIC_W-1:0]  reg_tail_magic   = TAIL_MAGIC_RST;
  logic [STATUS_W-1:0] reg_good_status  = GOOD_STATUS_RST;
  logic [LAG_W-1:0]    reg_display_lag  = DISPLAY_LAG_RST;

  // Ring state copies
  logic               ring_done  [RING];
  logic               ring_good  [RING];
  logic [FID_W-1:0]   ring_fid   [RING];
  logic [COUNT_W-1:0] ring_count = '0;
  int                 ring_active = 0;

  video_frame_ring_selector #(
    .SLOTS(RING)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one beat to the ring copy and return the result it should produce
  function automatic vfrs_out_t ring_predict(vfrs_in_t beat);
    vfrs_out_t res;
    int cur;
    int aim;
    int ofs;
    int s;
    logic hit;
    res = '0;
    hit = 1'b0;
    cur = ring_active;
    if (beat.operation == OP_FRAME_DONE) begin
      ring_done[cur] = 1'b1;
      ring_good[cur] = (beat.header_magic_seen == reg_header_magic) &&
                       (beat.tail_magic_seen == reg_tail_magic) &&
                       (beat.tail_status_seen == reg_good_status);
      if (ring_count != COUNT_MAX) ring_count = ring_count + 1'b1;
      ring_active = (cur + 1) % RING;
      ring_done[ring_active] = 1'b0;
      ring_fid[ring_active] = beat.source_frame_id;
    end else if (int'(ring_count) >= int'(reg_display_lag) + 1) begin
      aim = (cur + 4 * RING - 1 - int'(reg_display_lag)) % RING;
      // probe order 0, +1, -1, +2, -2
      for (int k = 0; k < 5; k++) begin
        ofs = (k % 2 == 1) ? (k + 1) / 2 : -(k / 2);
        s = (aim + RING + ofs) % RING;
        if (!hit && ring_done[s] && ring_good[s]) begin
          hit = 1'b1;
          res.found = 1'b1;
          res.display_slot = SLOT_W'(s);
          res.display_frame_id = ring_fid[s];
        end
      end
    end
    res.armed_slot = SLOT_W'(ring_active);
    return res;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: %s mismatch: expected %0h, got %0h", what, want, got);
  endtask

  // Register writes and input beats are predicted where they are accepted
  always @(posedge clk) begin
    in_fire_q <= rst_n && in_valid && in_ready;
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEADER_MAGIC: reg_header_magic = cfg_data;
        CFG_TAIL_MAGIC:   reg_tail_magic   = cfg_data;
        CFG_GOOD_STATUS:  reg_good_status  = cfg_data[STATUS_W-1:0];
        CFG_DISPLAY_LAG:  reg_display_lag  = cfg_data[LAG_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(ring_predict(in_data));
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result", '0, 32'(out_data));
      end else begin
        if (out_data.armed_slot != expected_results[0].armed_slot)
          note_mismatch("armed_slot", 32'(expected_results[0].armed_slot),
                        32'(out_data.armed_slot));
        if (out_data.found != expected_results[0].found)
          note_mismatch("found", 32'(expected_results[0].found), 32'(out_data.found));
        if (out_data.display_slot != expected_results[0].display_slot)
          note_mismatch("display_slot", 32'(expected_results[0].display_slot),
                        32'(out_data.display_slot));
        if (out_data.display_frame_id != expected_results[0].display_frame_id)
          note_mismatch("display_frame_id", 32'(expected_results[0].display_frame_id),
                        32'(out_data.display_frame_id));
        void'(expected_results.pop_front());
      end
    end
  end

  // Input driver: hold a beat until taken, then idle or present the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire_q) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_beats.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(cfg_idx_t idx, logic [MAGIC_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued beat is taken and every result has come back
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic vfrs_in_t display_beat();
    vfrs_in_t b;
    b.operation         = OP_DISPLAY;
    b.source_frame_id   = FID_W'($urandom);
    b.header_magic_seen = $urandom;
    b.tail_magic_seen   = $urandom;
    b.tail_status_seen  = STATUS_W'($urandom);
    return b;
  endfunction

  function automatic vfrs_in_t frame_beat(logic [FID_W-1:0] fid,
                                          logic [MAGIC_W-1:0] hdr,
                                          logic [MAGIC_W-1:0] tl,
                                          logic [STATUS_W-1:0] st);
    vfrs_in_t b;
    b.operation         = OP_FRAME_DONE;
    b.source_frame_id   = fid;
    b.header_magic_seen = hdr;
    b.tail_magic_seen   = tl;
    b.tail_status_seen  = st;
    return b;
  endfunction

  // Frames, mostly well-formed with a share of damaged ones, plus displays and noise
  task automatic queue_random(int n);
    vfrs_in_t b;
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 38) begin
        b = display_beat();
      end else if (r < 48) begin
        b = display_beat();
        b.operation = 1'($urandom_range(1));
      end else begin
        b = frame_beat(FID_W'($urandom), reg_header_magic, reg_tail_magic,
                       reg_good_status);
        if ($urandom_range(99) < 28) begin
          case ($urandom_range(3))
            0: b.header_magic_seen ^= 32'(1) << $urandom_range(31);
            1: b.tail_magic_seen ^= 32'(1) << $urandom_range(31);
            2: b.tail_status_seen ^= 8'(1) << $urandom_range(7);
            default: begin
              b.header_magic_seen = $urandom;
              b.tail_magic_seen   = $urandom;
              b.tail_status_seen  = STATUS_W'($urandom);
            end
          endcase
        end
      end
      pending_beats.push_back(b);
    end
  endtask

  initial begin
    for (int i = 0; i < RING; i++) begin
      ring_done[i]  = 1'b0;
      ring_good[i]  = 1'b0;
      ring_fid[i]   = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Phase 1: reset settings, directed beats first
    send_idle_pct = 16;
    recv_idle_pct = 46;
    // too few frames on an empty ring
    pending_beats.push_back(display_beat());
    pending_beats.push_back(frame_beat(16'hFFFF, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(frame_beat(16'h0000, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(display_beat());
    // five damaged frames in a row: every ready slot is bad, so no candidate
    pending_beats.push_back(frame_beat(16'h0001, 32'h0000_0000, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(frame_beat(16'hFFFF, HEADER_MAGIC_RST, 32'hFFFF_FFFF,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(frame_beat(16'h8000, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       8'hE1));
    pending_beats.push_back(frame_beat(16'h7FFF, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       8'h00));
    pending_beats.push_back(frame_beat(16'h5A5A, 32'hFFFF_FFFF, 32'h0000_0000,
                                       8'hFF));
    pending_beats.push_back(display_beat());
    // good frames again, displays land on the various probe offsets
    pending_beats.push_back(frame_beat(16'h1234, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(display_beat());
    pending_beats.push_back(frame_beat(16'hA5A5, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(display_beat());
    pending_beats.push_back(frame_beat(16'h0000, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(display_beat());
    pending_beats.push_back(frame_beat(16'hFFFF, HEADER_MAGIC_RST, TAIL_MAGIC_RST,
                                       GOOD_STATUS_RST));
    pending_beats.push_back(display_beat());
    pending_beats.push_back(display_beat());
    drain();
    queue_random(RANDOM_BEATS);
    drain();

    // Phase 2: all-ones header magic, all-zero tail magic, top status, no lag
    write_reg(CFG_HEADER_MAGIC, 32'hFFFF_FFFF);
    write_reg(CFG_TAIL_MAGIC, 32'h0000_0000);
    write_reg(CFG_GOOD_STATUS, 32'h0000_00FF);
    write_reg(CFG_DISPLAY_LAG, 32'h0000_0000);
    queue_random(RANDOM_BEATS);
    drain();

    // Phase 3: the opposite extremes, longest lag
    send_idle_pct = 46;
    recv_idle_pct = 16;
    write_reg(CFG_HEADER_MAGIC, 32'h0000_0000);
    write_reg(CFG_TAIL_MAGIC, 32'hFFFF_FFFF);
    write_reg(CFG_GOOD_STATUS, 32'h0000_0000);
    write_reg(CFG_DISPLAY_LAG, 32'h0000_000F);
    queue_random(RANDOM_BEATS);
    drain();

    // Phase 4: random settings, full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(CFG_HEADER_MAGIC, $urandom);
    write_reg(CFG_TAIL_MAGIC, $urandom);
    write_reg(CFG_GOOD_STATUS, 32'($urandom_range(255)));
    write_reg(CFG_DISPLAY_LAG, 32'($urandom_range(14, 1)));
    queue_random(RANDOM_BEATS);
    drain();

    repeat (32) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== video_frame_ring_selector.f =====
rtl/vfrs_pkg.sv
rtl/vfrs_wrap_add.sv
rtl/vfrs_ring.sv
rtl/vfrs_seq.sv
rtl/video_frame_ring_selector.sv
verif/testbench.sv
